// File: sv/i4dq_pkg.sv
package i4dq_pkg;

    localparam int unsigned CodeW   = 4;
    localparam int unsigned ScaleW  = 16;
    localparam int unsigned ValW    = 32;
    localparam int unsigned InDataW = 24;
    localparam int unsigned OutDataW = 64;

    localparam logic FmtFp32 = 1'b0;
    localparam logic FmtBf16 = 1'b1;
    localparam logic FmtReset = FmtBf16;

    localparam logic [31:0] QNan = 32'h7FC0_0000;
    localparam logic [31:0] ExpMask = 32'h7F80_0000;
    localparam logic [31:0] ManMask = 32'h007F_FFFF;

    // Exact FP32 of (code - 8) * fp16(scale).
    function automatic logic [31:0] scaled_code(input logic [3:0] code,
                                                input logic [15:0] scale);
        logic        s_sign;
        logic [4:0]  s_exp;
        logic [9:0]  s_man;
        logic        d_neg;
        logic [3:0]  d_mag;
        logic        sign;
        logic [10:0] sig;
        logic [4:0]  eff;
        logic [13:0] p;
        logic [3:0]  t;
        logic [7:0]  exp32;
        logic [36:0] sh;
        s_sign = scale[15];
        s_exp  = scale[14:10];
        s_man  = scale[9:0];
        d_neg  = ~code[3];
        d_mag  = d_neg ? (4'd8 - code) : (code - 4'd8);
        sign   = s_sign ^ d_neg;
        sig    = (s_exp == 5'd0) ? {1'b0, s_man} : {1'b1, s_man};
        eff    = (s_exp == 5'd0) ? 5'd1 : s_exp;
        p      = 14'(d_mag) * 14'(sig);
        t      = 4'd0;
        for (int i = 1; i < 14; i++) begin
            if (p[i]) t = 4'(i);
        end
        exp32 = 8'(t) + 8'(eff) + 8'd102;
        sh    = 37'(p) << (5'd23 - 5'(t));
        if (s_exp == 5'h1F) begin
            if (s_man != 10'd0)
                scaled_code = {s_sign, 8'hFF, 1'b1, s_man[8:0], 13'd0};
            else if (d_mag == 4'd0)
                scaled_code = QNan;
            else
                scaled_code = {sign, 8'hFF, 23'd0};
        end else if (d_mag == 4'd0 || (s_exp == 5'd0 && s_man == 10'd0)) begin
            scaled_code = {sign, 31'd0};
        end else begin
            scaled_code = {sign, exp32, sh[22:0]};
        end
    endfunction

    function automatic logic [31:0] to_bf16(input logic [31:0] bits);
        logic [32:0] sum;
        sum = 33'(bits) + 33'h7FFF + 33'(bits[16]);
        if ((bits & ExpMask) == ExpMask && (bits & ManMask) != 32'd0)
            to_bf16 = {16'd0, bits[31:23], 1'b1, bits[21:16]};
        else
            to_bf16 = {16'd0, sum[31:16]};
    endfunction

endpackage

// File: sv/int4_group_dequantizer_top.sv
// int4_group_dequantizer_top
// Dequantizes two packed int4 codes per word with one FP16 group scale.
// Input stream: s_axis_tdata = {group_scale[15:0], packed_codes[7:0]};
//   low nibble is the even column, high nibble the odd column.
// Output stream: m_axis_tdata = {odd_value[31:0], even_value[31:0]};
//   each is (code-8)*scale as FP32, or as BF16 (RNE) zero-extended.
// Config channel: one bit, output_format (0 FP32, 1 BF16), reset 1.
//   Write only while the block is idle.
// Datapath: an input register holds the word, and a single combinational
//   pass (small 4x11 multiply, leading-one search, rounding) feeds the
//   output register.
// Throughput: one word per cycle (single pass) unless the receiver stalls.
// Stall: ready propagates back through both registers; a stage may load
//   when it is empty or its content moves on in the same cycle, so a full
//   pipe holds two words while the receiver stalls.
// Reset (synchronous, active low) empties both stages and sets BF16 mode.
module int4_group_dequantizer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] packed_codes, [23:8] group_scale
    input  logic [i4dq_pkg::InDataW-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] even_value, [63:32] odd_value
    output logic [i4dq_pkg::OutDataW-1:0]  m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_data
);
    import i4dq_pkg::*;

    logic                r_fmt;
    logic                r_in_vld;
    logic [InDataW-1:0]  r_in;
    logic                r_out_vld;
    logic [OutDataW-1:0] r_out;
    logic                out_load;
    logic                in_load;
    logic [ValW-1:0]     even_v;
    logic [ValW-1:0]     odd_v;

    assign o_cfg_ready   = 1'b1;
    assign out_load      = ~r_out_vld | m_axis_tready;
    assign in_load       = ~r_in_vld | out_load;
    assign s_axis_tready = in_load;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    i4dq_lane u_even (.i_code(r_in[3:0]), .i_scale(r_in[23:8]), .i_fmt(r_fmt),
                      .o_value(even_v));
    i4dq_lane u_odd  (.i_code(r_in[7:4]), .i_scale(r_in[23:8]), .i_fmt(r_fmt),
                      .o_value(odd_v));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= FmtReset;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) r_fmt <= i_cfg_data;
            if (in_load) r_in_vld <= s_axis_tvalid;
            if (out_load) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && s_axis_tvalid) r_in <= s_axis_tdata;
        if (out_load && r_in_vld) r_out <= {odd_v, even_v};
    end

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // full pipe and stalled output blocks input
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while pipe full");
    // an accepted word reaches the input stage
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_in_vld)
        else $error("word lost");

endmodule

// File: sv/i4dq_lane.sv
module i4dq_lane (
    input  logic [i4dq_pkg::CodeW-1:0]  i_code,
    input  logic [i4dq_pkg::ScaleW-1:0] i_scale,
    input  logic                        i_fmt,
    output logic [i4dq_pkg::ValW-1:0]   o_value
);
    import i4dq_pkg::*;

    logic [ValW-1:0] prod;

    assign prod    = scaled_code(i_code, i_scale);
    assign o_value = (i_fmt == FmtBf16) ? to_bf16(prod) : prod;

endmodule
